### rtl/core/nearest_record_match_top_macros.svh
// ----------------------------------------------------------------------------
// nearest_record_match_top_macros.svh
// Assertion macros shared by the nearest record match RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_RECORD_MATCH_TOP_MACROS_SVH
`define NEAREST_RECORD_MATCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Combinational invariant, checked at every clock edge out of reset.
`define NRM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define NRM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NRM_ASSERT(lbl, expr, msg)
`define NRM_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### rtl/core/nrm_pkg.sv
// ----------------------------------------------------------------------------
// nrm_pkg
// Types, codes and constants of the nearest record match block.
// ----------------------------------------------------------------------------
package nrm_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  // Request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Query kinds
  localparam logic [1:0] KIND_ELIGIBLE = 2'd0;
  localparam logic [1:0] KIND_STOP     = 2'd2;

  // Result status
  localparam logic [1:0] STAT_MAPPED     = 2'd0;
  localparam logic [1:0] STAT_NOT_MAPPED = 2'd1;
  localparam logic [1:0] STAT_SKIPPED    = 2'd2;
  localparam logic [1:0] STAT_STOPPED    = 2'd3;

  // Classified commands
  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_CLEAR      = 3'd1;
  localparam logic [2:0] CMD_QUERY_SCAN = 3'd2;
  localparam logic [2:0] CMD_QUERY_STOP = 3'd3;
  localparam logic [2:0] CMD_QUERY_SKIP = 3'd4;

  // Candidate record, last field in the lowest bits
  typedef struct packed {
    logic [31:0] y;
    logic [31:0] x;
    logic [19:0] off;
    logic        dir;
    logic [23:0] link;
  } cand_t;

  localparam int CAND_W = $bits(cand_t);

  typedef struct packed {
    logic [2:0] op;
    cand_t      rec;
  } cmd_t;

  typedef struct packed {
    logic [23:0] tol;
    logic [23:0] base;
  } cfg_t;

  typedef struct packed {
    logic        by_pos;
    logic [19:0] gap;
    logic [24:0] index;
    logic [1:0]  status;
  } res_t;

endpackage

### rtl/core/nearest_record_match_top.sv
// ----------------------------------------------------------------------------
// nearest_record_match_top
// Candidate record table with nearest-offset query and position early exit.
// ----------------------------------------------------------------------------
// Load transactions fill a table of up to TABLE_DEPTH candidate records in
// arrival order; a clear transaction empties it and releases the stop flag.
// A query scans the loaded entries in order, one entry per clock through the
// single read port of the candidate RAM. An entry within xy_tolerance ends
// the scan early; on an empty table the scan reads no entry. Loads, clears
// and skip/stop queries are handled in the back end without a scan.
// A two-entry command queue lets the input side keep accepting while a scan
// runs or a result waits on out_tready. The table needs no clearing pass:
// only entries below the fill count are ever read. Config: xy_tolerance at
// 0x0, index_base at 0x4 (word aligned, paddr[1:0] ignored); write only
// while the block is idle.
// ----------------------------------------------------------------------------
module nearest_record_match_top #(
  parameter int TABLE_DEPTH = nrm_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: link_id[23:0], direction[24], offset_pos[44:25], x_pos[76:45],
  //        y_pos[108:77], zero pad[111:109]
  input  logic [111:0] in_tdata,
  // tuser: req_type[1:0], rec_kind[3:2]
  input  logic [3:0]   in_tuser,
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: best_index[24:0], offset_gap[44:25], zero pad[47:45]
  output logic [47:0]  out_tdata,
  // tuser: status[1:0], by_position[2]
  output logic [2:0]   out_tuser,
  // Configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import nrm_pkg::*;

  logic [23:0] tol_r;
  logic [23:0] base_r;
  logic        cfg_wr;
  cfg_t        cfg;
  logic        head_valid;
  cmd_t        head;
  logic        pop;
  res_t        res;

  // Register file; pready is tied high so the access phase always completes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      base_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        base_r <= cfg_pwdata[23:0];
      end else begin
        tol_r <= cfg_pwdata[23:0];
      end
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? {8'd0, base_r} : {8'd0, tol_r};
  assign cfg        = '{tol: tol_r, base: base_r};

  // Front end: accept, classify, queue
  nrm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_user    (in_tuser),
    .in_data    (in_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back end: table writes, scan pipeline, result register
  nrm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {3'd0, res.gap, res.index};
  assign out_tuser = {res.by_pos, res.status};

endmodule

### rtl/core/nrm_ram.sv
// ----------------------------------------------------------------------------
// nrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/nrm_front.sv
// ----------------------------------------------------------------------------
// nrm_front
// Accepts input transactions, classifies them and queues commands.
// ----------------------------------------------------------------------------
module nrm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nrm_pkg::IN_TUSER_W-1:0]    in_user,
  input  logic [nrm_pkg::IN_TDATA_W-1:0]    in_data,
  output logic                              head_valid,
  output nrm_pkg::cmd_t                     head,
  input  logic                              pop
);
  import nrm_pkg::*;

  cmd_t           q_mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] q_cnt_r, q_cnt_nxt;

  logic [1:0] req;
  logic [1:0] kind;
  logic       push;
  logic       drop;
  cmd_t       cmd;

  assign req  = in_user[1:0];
  assign kind = in_user[3:2];

  // Unused request code is accepted and dropped
  assign drop = (req != REQ_LOAD) && (req != REQ_QUERY) && (req != REQ_CLEAR);

  always_comb begin
    cmd.rec = cand_t'(in_data[CAND_W-1:0]);
    case (req)
      REQ_LOAD:  cmd.op = CMD_LOAD;
      REQ_CLEAR: cmd.op = CMD_CLEAR;
      REQ_QUERY: begin
        if (kind == KIND_STOP) begin
          cmd.op = CMD_QUERY_STOP;
        end else if (kind == KIND_ELIGIBLE) begin
          cmd.op = CMD_QUERY_SCAN;
        end else begin
          cmd.op = CMD_QUERY_SKIP;
        end
      end
      default:   cmd.op = CMD_CLEAR;
    endcase
  end

  assign in_ready   = (q_cnt_r != QCW'(QDEPTH));
  assign push       = in_valid && in_ready && !drop;
  assign head_valid = (q_cnt_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + QCW'(1);
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

`include "nearest_record_match_top_macros.svh"

  `NRM_ASSERT(a_q_bound, q_cnt_r <= QCW'(QDEPTH), "command queue overflow")
  `NRM_ASSERT(a_pop_nonempty, !pop || head_valid, "pop from empty command queue")

endmodule

### rtl/core/nrm_back.sv
// ----------------------------------------------------------------------------
// nrm_back
// Executes queued commands: table loads, clears and pipelined query scans.
// ----------------------------------------------------------------------------
module nrm_back #(
  parameter int TABLE_DEPTH = nrm_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  nrm_pkg::cmd_t  head,
  output logic           pop,
  input  nrm_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output nrm_pkg::res_t  out_res
);
  import nrm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic FSM_IDLE = 1'b0;
  localparam logic FSM_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          stop_r, stop_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  cand_t         q_r;

  // Scan pipeline
  logic          p1_v_r, p1_v_nxt;
  logic [AW-1:0] p1_idx_r;
  logic          p2_v_r, p2_v_nxt;
  logic [AW-1:0] p2_idx_r;
  logic          p2_match_r;
  logic [19:0]   p2_gap_r;
  logic [31:0]   p2_ax_r, p2_ay_r;

  logic          found_r, found_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [19:0]   gap_r, gap_nxt;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  logic [CAND_W-1:0] ram_rdata;
  cand_t             rd;
  logic              ram_we;
  logic              issue;
  logic              out_free;
  logic              is_query;
  logic              hit, take, finish;
  logic              s2_match;
  logic [19:0]       s2_gap;
  logic [31:0]       s2_ax, s2_ay;
  logic [23:0]       tol;

  assign tol      = cfg.tol;
  assign out_free = !out_valid_r || out_ready;
  assign is_query = (head.op == CMD_QUERY_SCAN) || (head.op == CMD_QUERY_STOP) ||
                    (head.op == CMD_QUERY_SKIP);
  assign pop      = (state_r == FSM_IDLE) && head_valid && (!is_query || out_free);
  assign ram_we   = pop && (head.op == CMD_LOAD) && (cnt_r < CW'(TABLE_DEPTH));
  assign issue    = (state_r == FSM_SCAN) && (idx_r < cnt_r) && !hit;

  nrm_ram #(
    .WIDTH (CAND_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (head.rec),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd = cand_t'(ram_rdata);

  // Stage 2: compare one entry against the query
  always_comb begin
    s2_match = (rd.link == q_r.link) && (rd.dir == q_r.dir);
    s2_gap   = (rd.off >= q_r.off) ? rd.off - q_r.off : q_r.off - rd.off;
    s2_ax    = ($signed(rd.x) >= $signed(q_r.x)) ? rd.x - q_r.x : q_r.x - rd.x;
    s2_ay    = ($signed(rd.y) >= $signed(q_r.y)) ? rd.y - q_r.y : q_r.y - rd.y;
  end

  // Stage 3: best-so-far update and position exit
  always_comb begin
    hit    = (state_r == FSM_SCAN) && p2_v_r && p2_match_r &&
             (p2_ax_r <= {8'd0, tol}) && (p2_ay_r <= {8'd0, tol});
    take   = p2_v_r && p2_match_r && (!found_r || (p2_gap_r < gap_r));
    finish = (state_r == FSM_SCAN) &&
             (hit || ((idx_r == cnt_r) && !p1_v_r && !p2_v_r));
    found_nxt = found_r || (p2_v_r && p2_match_r);
    best_nxt  = (hit || take) ? p2_idx_r : best_r;
    gap_nxt   = take ? p2_gap_r : gap_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    stop_nxt      = stop_r;
    idx_nxt       = issue ? idx_r + CW'(1) : idx_r;
    p1_v_nxt      = issue;
    p2_v_nxt      = p1_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;

    if (pop) begin
      case (head.op)
        CMD_LOAD: begin
          if (ram_we) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        CMD_CLEAR: begin
          cnt_nxt  = '0;
          stop_nxt = 1'b0;
        end
        CMD_QUERY_STOP: begin
          stop_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{by_pos: 1'b0, gap: '0, index: '0, status: STAT_STOPPED};
        end
        CMD_QUERY_SKIP: begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{by_pos: 1'b0, gap: '0, index: '0,
                            status: stop_r ? STAT_STOPPED : STAT_SKIPPED};
        end
        CMD_QUERY_SCAN: begin
          if (stop_r) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{by_pos: 1'b0, gap: '0, index: '0, status: STAT_STOPPED};
          end else begin
            state_nxt = FSM_SCAN;
            idx_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (finish) begin
      state_nxt     = FSM_IDLE;
      p1_v_nxt      = 1'b0;
      p2_v_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (found_nxt) begin
        out_res_nxt = '{by_pos: hit, gap: gap_nxt,
                        index: {1'b0, cfg.base} + 25'(best_nxt), status: STAT_MAPPED};
      end else begin
        out_res_nxt = '{by_pos: 1'b0, gap: '0, index: '0, status: STAT_NOT_MAPPED};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      idx_r       <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stop_r      <= stop_nxt;
      idx_r       <= idx_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      found_r     <= (pop && (head.op == CMD_QUERY_SCAN)) ? 1'b0 : found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == CMD_QUERY_SCAN)) begin
      q_r <= head.rec;
    end
    p1_idx_r   <= idx_r[AW-1:0];
    p2_idx_r   <= p1_idx_r;
    p2_match_r <= s2_match;
    p2_gap_r   <= s2_gap;
    p2_ax_r    <= s2_ax;
    p2_ay_r    <= s2_ay;
    best_r     <= best_nxt;
    gap_r      <= gap_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`include "nearest_record_match_top_macros.svh"

  `NRM_ASSERT(a_idx_bound, (state_r != FSM_SCAN) || (idx_r <= cnt_r),
              "scan index ran past the loaded entries")
  `NRM_ASSERT(a_load_room, !ram_we || (cnt_r < CW'(TABLE_DEPTH)),
              "table write while full")
  `NRM_ASSERT(a_no_pop_scan, (state_r != FSM_SCAN) || !pop,
              "command taken during a scan")
  `NRM_ASSERT_NEXT(a_finish_idle, finish, (state_r == FSM_IDLE) && out_valid_r,
                   "scan end did not post a result")

endmodule
